// ===== hdl/frame_receiver_with_ack_assert.svh =====
// Assertion macros shared by the frame receiver modules.
// Depends on nothing; the three submodules include it after their timescale line.
`ifndef FRAME_RECEIVER_WITH_ACK_ASSERT_SVH
`define FRAME_RECEIVER_WITH_ACK_ASSERT_SVH

// Condition holds at every edge outside reset
`define FRWA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define FRWA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle
`define FRWA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/frwa_pkg.sv =====
// Shared types and constants of the frame receiver with acknowledge.
// Used by the parser, the acknowledge queue, the transmitter and the top level.
`timescale 1ns / 1ps

package frwa_pkg;

   // Frame format
   localparam logic [7:0]  HDR0           = 8'hBB;
   localparam logic [7:0]  HDR1           = 8'h00;
   localparam logic [15:0] CMD_MOTION     = 16'h0101;
   localparam logic [7:0]  PAY_OPEN       = 8'h01;
   localparam logic [7:0]  PAY_STOP       = 8'h02;
   localparam logic [7:0]  PAY_CLOSE      = 8'h04;
   localparam logic [7:0]  ADDR_RESET     = 8'd2;
   localparam logic        STATUS_GOOD    = 1'b0;
   localparam logic        STATUS_BAD     = 1'b1;

   // Byte positions within a received frame
   localparam int POS_HDR1     = 1;
   localparam int POS_CMD_LO   = 2;
   localparam int POS_CMD_HI   = 3;
   localparam int POS_ADDR     = 4;
   localparam int POS_LEN_LO   = 6;
   localparam int POS_LEN_HI   = 7;
   localparam int POS_PAYLOAD  = 8;

   // Frame sizing
   localparam int MAX_PAYLOAD    = 246;
   localparam int FRAME_OVERHEAD = 10;
   localparam int FRAME_MAX      = MAX_PAYLOAD + FRAME_OVERHEAD;
   localparam int IDX_W          = $clog2(FRAME_MAX);
   localparam int SIZE_W         = $clog2(FRAME_MAX + 1);

   // Acknowledge frame
   localparam int ACK_LEN   = 10;
   localparam int ACK_CNT_W = $clog2(ACK_LEN);
   localparam logic [ACK_CNT_W-1:0] ACK_POS_SYNC0  = ACK_CNT_W'(0);
   localparam logic [ACK_CNT_W-1:0] ACK_POS_SYNC1  = ACK_CNT_W'(1);
   localparam logic [ACK_CNT_W-1:0] ACK_POS_CMD_LO = ACK_CNT_W'(2);
   localparam logic [ACK_CNT_W-1:0] ACK_POS_CMD_HI = ACK_CNT_W'(3);
   localparam logic [ACK_CNT_W-1:0] ACK_POS_ADDR   = ACK_CNT_W'(4);
   localparam logic [ACK_CNT_W-1:0] ACK_POS_STATUS = ACK_CNT_W'(5);
   localparam logic [ACK_CNT_W-1:0] ACK_POS_PAD0   = ACK_CNT_W'(6);
   localparam logic [ACK_CNT_W-1:0] ACK_POS_PAD1   = ACK_CNT_W'(7);
   localparam logic [ACK_CNT_W-1:0] ACK_POS_SUM_LO = ACK_CNT_W'(8);
   localparam logic [ACK_CNT_W-1:0] ACK_POS_SUM_HI = ACK_CNT_W'(9);

   // Acknowledge queue
   localparam int ACK_FIFO_DEPTH = 2;
   localparam int ACK_FIFO_AW    = $clog2(ACK_FIFO_DEPTH);

   typedef enum logic [1:0] {
      MOTION_NONE  = 2'd0,
      MOTION_OPEN  = 2'd1,
      MOTION_STOP  = 2'd2,
      MOTION_CLOSE = 2'd3
   } motion_type;

   // One pending acknowledge
   typedef struct packed {
      logic [15:0] cmd;
      logic [7:0]  addr;
      logic        status;
      motion_type  motion;
   } ack_desc_type;

endpackage

// ===== hdl/frwa_parser.sv =====
// Front end: header hunt, field capture, checksum and motion command decode.
// Depends on frwa_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "frame_receiver_with_ack_assert.svh"

module frwa_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            rx_byte,
   input  logic [7:0]            dev_addr,
   output logic                  push,
   output frwa_pkg::ack_desc_type push_desc
);

   logic [frwa_pkg::IDX_W-1:0]  idx_ff,   idx_in;
   logic [15:0]                 sum_ff,   sum_in;
   logic [7:0]                  cand_ff,  cand_in;
   logic [15:0]                 cmd_ff,   cmd_in;
   logic [7:0]                  addr_ff,  addr_in;
   logic [7:0]                  lenlo_ff, lenlo_in;
   logic [frwa_pkg::SIZE_W-1:0] size_ff,  size_in;
   logic [7:0]                  first_ff, first_in;
   frwa_pkg::motion_type        motion_ff, motion_in;

   logic [15:0]                 len;
   logic                        len_bad;
   logic [frwa_pkg::SIZE_W:0]   pos_ahead;
   logic                        sum_good;

   assign len       = {rx_byte, lenlo_ff};
   assign len_bad   = (len > 16'(frwa_pkg::MAX_PAYLOAD)) ||
                      ({1'b0, len} + 17'(frwa_pkg::FRAME_OVERHEAD) > 17'hFFFF);
   assign pos_ahead = (frwa_pkg::SIZE_W+1)'(idx_ff) + (frwa_pkg::SIZE_W+1)'(2);
   assign sum_good  = ({rx_byte, cand_ff} == sum_ff);

   // Advance the frame parser by one transaction
   always_comb begin
      idx_in    = idx_ff;
      sum_in    = sum_ff;
      cand_in   = cand_ff;
      cmd_in    = cmd_ff;
      addr_in   = addr_ff;
      lenlo_in  = lenlo_ff;
      size_in   = size_ff;
      first_in  = first_ff;
      motion_in = motion_ff;
      push      = 1'b0;
      if (accept) begin
         idx_in = idx_ff + frwa_pkg::IDX_W'(1);
         priority if (idx_ff == '0) begin
            cand_in = rx_byte;
            sum_in  = 16'(rx_byte);
         end else if (idx_ff == frwa_pkg::IDX_W'(frwa_pkg::POS_HDR1)) begin
            if (cand_ff == frwa_pkg::HDR0 && rx_byte == frwa_pkg::HDR1) begin
               sum_in = 16'(frwa_pkg::HDR0);
            end else begin
               // resync: this byte is the new header candidate
               cand_in = rx_byte;
               sum_in  = 16'(rx_byte);
               idx_in  = frwa_pkg::IDX_W'(1);
            end
         end else if (idx_ff < frwa_pkg::IDX_W'(frwa_pkg::POS_PAYLOAD)) begin
            sum_in = sum_ff + 16'(rx_byte);
            if (idx_ff == frwa_pkg::IDX_W'(frwa_pkg::POS_CMD_LO)) begin
               cmd_in[7:0] = rx_byte;
            end
            if (idx_ff == frwa_pkg::IDX_W'(frwa_pkg::POS_CMD_HI)) begin
               cmd_in[15:8] = rx_byte;
            end
            if (idx_ff == frwa_pkg::IDX_W'(frwa_pkg::POS_ADDR)) begin
               addr_in = rx_byte;
            end
            if (idx_ff == frwa_pkg::IDX_W'(frwa_pkg::POS_LEN_LO)) begin
               lenlo_in = rx_byte;
            end
            if (idx_ff == frwa_pkg::IDX_W'(frwa_pkg::POS_LEN_HI)) begin
               if (len_bad) begin
                  // drop oversized frame and hunt again
                  idx_in = '0;
                  sum_in = '0;
               end else begin
                  size_in = frwa_pkg::SIZE_W'(17'(len) + 17'(frwa_pkg::FRAME_OVERHEAD));
               end
            end
         end else begin
            if (idx_ff == frwa_pkg::IDX_W'(frwa_pkg::POS_PAYLOAD)) begin
               first_in = rx_byte;
            end
            priority if (pos_ahead < (frwa_pkg::SIZE_W+1)'(size_ff)) begin
               sum_in = sum_ff + 16'(rx_byte);
            end else if (pos_ahead == (frwa_pkg::SIZE_W+1)'(size_ff)) begin
               cand_in = rx_byte;
            end else begin
               // last checksum byte: close the frame
               idx_in = '0;
               sum_in = '0;
               if (addr_ff == dev_addr) begin
                  push = 1'b1;
                  if (sum_good && cmd_ff == frwa_pkg::CMD_MOTION) begin
                     priority if (first_ff == frwa_pkg::PAY_OPEN) begin
                        motion_in = frwa_pkg::MOTION_OPEN;
                     end else if (first_ff == frwa_pkg::PAY_STOP) begin
                        motion_in = frwa_pkg::MOTION_STOP;
                     end else if (first_ff == frwa_pkg::PAY_CLOSE) begin
                        motion_in = frwa_pkg::MOTION_CLOSE;
                     end else begin
                        motion_in = motion_ff;
                     end
                  end
               end
            end
         end
      end
   end

   // Describe the acknowledge to queue
   always_comb begin
      push_desc.cmd    = cmd_ff;
      push_desc.addr   = addr_ff;
      push_desc.status = sum_good ? frwa_pkg::STATUS_GOOD : frwa_pkg::STATUS_BAD;
      push_desc.motion = motion_in;
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         sum_ff    <= '0;
         motion_ff <= frwa_pkg::MOTION_NONE;
      end else begin
         idx_ff    <= idx_in;
         sum_ff    <= sum_in;
         motion_ff <= motion_in;
      end
   end

   // Hold captured fields
   always_ff @(posedge clock) begin
      cand_ff  <= cand_in;
      cmd_ff   <= cmd_in;
      addr_ff  <= addr_in;
      lenlo_ff <= lenlo_in;
      size_ff  <= size_in;
      first_ff <= first_in;
   end

   `FRWA_ASSERT_NEXT(a_push_restarts, clock, reset, push, idx_ff == '0,
      "frame index not cleared after an acknowledge")
   `FRWA_ASSERT_IMPLY(a_push_needs_accept, clock, reset, push, accept,
      "acknowledge queued without a transaction")
   `FRWA_ASSERT_IMPLY(a_motion_only_on_push, clock, reset, motion_in != motion_ff, push,
      "motion state changed outside a completed frame")

endmodule

// ===== hdl/frwa_ack_fifo.sv =====
// Short queue of pending acknowledges between parser and transmitter.
// Depends on frwa_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "frame_receiver_with_ack_assert.svh"

module frwa_ack_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  frwa_pkg::ack_desc_type push_desc,
   input  logic                   pop,
   output logic                   full,
   output logic                   not_empty,
   output frwa_pkg::ack_desc_type head_desc
);

   frwa_pkg::ack_desc_type            mem_ff [frwa_pkg::ACK_FIFO_DEPTH];
   logic [frwa_pkg::ACK_FIFO_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [frwa_pkg::ACK_FIFO_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [frwa_pkg::ACK_FIFO_AW:0]    count_ff,  count_in;

   assign full      = (count_ff == (frwa_pkg::ACK_FIFO_AW+1)'(frwa_pkg::ACK_FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_desc = mem_ff[rd_ptr_ff];

   // Step pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == frwa_pkg::ACK_FIFO_AW'(frwa_pkg::ACK_FIFO_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + frwa_pkg::ACK_FIFO_AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == frwa_pkg::ACK_FIFO_AW'(frwa_pkg::ACK_FIFO_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + frwa_pkg::ACK_FIFO_AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (frwa_pkg::ACK_FIFO_AW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (frwa_pkg::ACK_FIFO_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   `FRWA_ASSERT_IMPLY(a_no_push_full, clock, reset, push, !full,
      "acknowledge pushed into a full queue")
   `FRWA_ASSERT_IMPLY(a_no_pop_empty, clock, reset, pop, not_empty,
      "acknowledge popped from an empty queue")
   `FRWA_ASSERT_ALWAYS(a_count_bound, clock, reset,
      count_ff <= (frwa_pkg::ACK_FIFO_AW+1)'(frwa_pkg::ACK_FIFO_DEPTH),
      "queue fill count beyond depth")

endmodule

// ===== hdl/frwa_ack_tx.sv =====
// Back end: serialises one queued acknowledge into ten output bytes.
// Depends on frwa_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "frame_receiver_with_ack_assert.svh"

module frwa_ack_tx (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_not_empty,
   input  frwa_pkg::ack_desc_type q_head,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [15:0]            rsp_tdata,
   output logic                   rsp_tlast
);

   frwa_pkg::ack_desc_type            desc_ff,  desc_in;
   logic                              busy_ff,  busy_in;
   logic [frwa_pkg::ACK_CNT_W-1:0]    cnt_ff,   cnt_in;
   logic                              valid_ff, valid_in;
   logic [15:0]                       data_ff,  data_in;
   logic                              last_ff,  last_in;

   logic                              advance;
   logic                              at_last;
   logic [9:0]                        ack_sum;
   logic [7:0]                        ack_byte;

   assign advance = busy_ff && (!valid_ff || rsp_tready);
   assign at_last = (cnt_ff == frwa_pkg::ACK_POS_SUM_HI);
   assign q_pop   = q_not_empty && (!busy_ff || (advance && at_last));

   assign ack_sum = 10'(frwa_pkg::HDR0) + 10'(desc_ff.cmd[7:0]) + 10'(desc_ff.cmd[15:8])
                  + 10'(desc_ff.addr) + 10'(desc_ff.status);

   // Select the current acknowledge byte
   always_comb begin
      unique case (cnt_ff)
         frwa_pkg::ACK_POS_SYNC0:  ack_byte = frwa_pkg::HDR0;
         frwa_pkg::ACK_POS_SYNC1:  ack_byte = frwa_pkg::HDR1;
         frwa_pkg::ACK_POS_CMD_LO: ack_byte = desc_ff.cmd[7:0];
         frwa_pkg::ACK_POS_CMD_HI: ack_byte = desc_ff.cmd[15:8];
         frwa_pkg::ACK_POS_ADDR:   ack_byte = desc_ff.addr;
         frwa_pkg::ACK_POS_STATUS: ack_byte = 8'(desc_ff.status);
         frwa_pkg::ACK_POS_PAD0:   ack_byte = 8'h00;
         frwa_pkg::ACK_POS_PAD1:   ack_byte = 8'h00;
         frwa_pkg::ACK_POS_SUM_LO: ack_byte = ack_sum[7:0];
         frwa_pkg::ACK_POS_SUM_HI: ack_byte = 8'(ack_sum[9:8]);
         default:                  ack_byte = 8'h00;
      endcase
   end

   // Advance the byte counter and load the next acknowledge
   always_comb begin
      desc_in = desc_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (q_pop) begin
         desc_in = q_head;
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (advance) begin
         if (at_last) begin
            busy_in = 1'b0;
            cnt_in  = '0;
         end else begin
            cnt_in = cnt_ff + frwa_pkg::ACK_CNT_W'(1);
         end
      end
   end

   // Load the output register when it is free or being drained
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (advance) begin
         valid_in = 1'b1;
         data_in  = {6'b0, 2'(desc_ff.motion), ack_byte};
         last_in  = at_last;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   `FRWA_ASSERT_IMPLY(a_idle_cnt_zero, clock, reset, !busy_ff, cnt_ff == '0,
      "byte counter moved while idle")
   `FRWA_ASSERT_NEXT(a_last_marked, clock, reset, advance && at_last, rsp_tlast && rsp_tvalid,
      "final acknowledge byte not marked")
   `FRWA_ASSERT_IMPLY(a_cnt_bound, clock, reset, busy_ff,
      cnt_ff <= frwa_pkg::ACK_POS_SUM_HI, "byte counter beyond acknowledge length")

endmodule

// ===== hdl/frame_receiver_with_ack.sv =====
// Top level of the frame receiver with acknowledge: address register and glue.
// Depends on frwa_pkg, frwa_parser, frwa_ack_fifo and frwa_ack_tx.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata[7:0] rx_byte
//   rsp      out        rsp_tvalid/rsp_tready  tdata[7:0] tx_byte, [9:8] motion_state;
//                                              tlast last_byte
//   csr      in         csr_valid/csr_ready    csr_data[7:0] device_address
//
// One received byte per cycle unless stalled; a matching frame's last byte queues its ack.
// The transmitter sends ten bytes per acknowledge, one per cycle while rsp_tready holds.
// req_tready drops only while the two-entry acknowledge queue is full.
// Synchronous reset: hunt restarts, queue empties, motion none, address 2.
// csr writes are taken every cycle.
`timescale 1ns / 1ps

module frame_receiver_with_ack (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] tx_byte, [9:8] motion_state, rest zero
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // [7:0] device_address
);

   logic [7:0]             dev_addr_ff, dev_addr_in;
   logic                   accept;
   logic                   push;
   frwa_pkg::ack_desc_type push_desc;
   logic                   q_full;
   logic                   q_not_empty;
   logic                   q_pop;
   frwa_pkg::ack_desc_type q_head;

   // Take the device address on every csr transaction
   assign csr_ready   = 1'b1;
   assign dev_addr_in = (csr_valid && csr_ready) ? csr_data : dev_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= frwa_pkg::ADDR_RESET;
      end else begin
         dev_addr_ff <= dev_addr_in;
      end
   end

   // Stall the receive side only when no acknowledge slot is free
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   frwa_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_tdata),
      .dev_addr  (dev_addr_ff),
      .push      (push),
      .push_desc (push_desc)
   );

   frwa_ack_fifo u_ack_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_desc (q_head)
   );

   frwa_ack_tx u_ack_tx (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
